FILE: design/sobel_pkg.sv
// Package for the Sobel edge threshold block: sizes, register indexes,
// reset values and the frame dimension clamp. No dependencies.
package sobel_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W  = 8;
	localparam int POS_W  = 10;
	localparam int CFG_W  = 11;
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int GRAD_W = 11;
	localparam int SQ_W   = 20;
	localparam int MAG_W  = SQ_W + 1;
	localparam int LIM_W  = CFG_W + 1;
	localparam int LSQ_W  = 2 * CFG_W + 1;

	localparam logic [CFG_W-1:0] THRESHOLD_RST = CFG_W'(100);
	localparam logic [CFG_W-1:0] WIDTH_RST     = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RST    = CFG_W'(480);
	localparam logic [CFG_W-1:0] MIN_DIM       = CFG_W'(3);
	localparam logic [CFG_W-1:0] WIDTH_MAX     = CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] HEIGHT_MAX    = CFG_W'(MAX_HEIGHT);

	localparam logic [PIX_W-1:0] EDGE_VAL    = '0;
	localparam logic [PIX_W-1:0] NO_EDGE_VAL = 8'd255;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WIDTH     = 2'd1,
		REG_HEIGHT    = 2'd2
	} reg_idx_t;

	typedef logic [2*PIX_W-1:0] line_word_t;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		begin
			if (v < MIN_DIM) r = MIN_DIM;
			else if (v > hi) r = hi;
			else r = v;
			return r;
		end
	endfunction

endpackage

FILE: design/sobel_if.sv
// Channel interfaces of the Sobel edge threshold block: pixel input,
// result output and configuration write. Depends on sobel_pkg.
interface sobel_pix_if;
	logic                         valid;
	logic                         ready;
	logic [sobel_pkg::PIX_W-1:0]  pixel_in;
	logic                         frame_start;
	modport source (output valid, pixel_in, frame_start, input ready);
	modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

interface sobel_res_if;
	logic                         valid;
	logic                         ready;
	logic [sobel_pkg::PIX_W-1:0]  edge_pixel;
	logic [sobel_pkg::POS_W-1:0]  out_col;
	logic [sobel_pkg::POS_W-1:0]  out_row;
	logic                         frame_last;
	modport source (output valid, edge_pixel, out_col, out_row, frame_last, input ready);
	modport sink   (input valid, edge_pixel, out_col, out_row, frame_last, output ready);
endinterface

interface sobel_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   index;
	logic [sobel_pkg::CFG_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/sobel_edge_threshold.sv
// Top level of the Sobel edge threshold block: line memory, 3x3 window,
// gradient and threshold pipeline. Depends on sobel_pkg and sobel_if.
//
//   channel  dir  payload                                   request when
//   pix      in   pixel_in, frame_start                      valid && ready
//   res      out  edge_pixel, out_col, out_row, frame_last   valid && ready
//   cfg      in   index, data                                valid (ready is held high)
//
// One pixel is taken each clock when stage 1 can advance and clearing is done;
// a result passes stages 1, 2 and 3 and the output register. The pace is set
// by the single line memory, read at the pixel's column and written back when
// the pixel leaves the first stage. After reset a clearing pass writes zero to
// all 1024 line memory entries, one per cycle; pixels are refused until it ends.
// Each stage moves when the stage after it is empty or moving, so a stalled
// result still lets earlier stages fill.
module sobel_edge_threshold (
	input  logic            clk,
	input  logic            arst_n,
	sobel_pix_if.sink       pix,
	sobel_res_if.source     res,
	sobel_cfg_if.sink       cfg
);
	import sobel_pkg::*;

	logic [CFG_W-1:0]  threshold_q, width_q, height_q;
	logic [LSQ_W-1:0]  lim_sq_q;
	logic [LIM_W-1:0]  lim;
	logic [2*LIM_W-1:0] lim_prod;

	line_word_t        mem [MAX_WIDTH];
	logic [ADDR_W:0]   clr_q;
	logic              clr_done;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	line_word_t        mem_wd;

	logic [POS_W-1:0]  col_count_q, row_count_q;
	logic [PIX_W-1:0]  win_q [6];

	logic              acc, adv_s1, adv_s2, adv_s3, adv_o, s1_exit;
	logic [CFG_W-1:0]  c_a, r_a, c_n, r_n;
	logic [POS_W-1:0]  c_cur, r_cur;
	logic              prod_cur, last_cur;

	logic              v_s1, prod_s1, last_s1, fwd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [POS_W-1:0]  ocol_s1, orow_s1;
	logic [PIX_W-1:0]  bot_s1;
	line_word_t        rd_s1, fwd_word_s1, word_eff;
	logic [PIX_W-1:0]  top_eff, mid_eff;
	logic [POS_W-1:0]  left, right, upper, lower;
	logic signed [GRAD_W-1:0] gx, gy;

	logic              v_s2, last_s2;
	logic [POS_W-1:0]  ocol_s2, orow_s2;
	logic signed [GRAD_W-1:0] gx_s2, gy_s2;
	logic signed [2*GRAD_W-1:0] gx_prod, gy_prod;

	logic              v_s3, last_s3;
	logic [POS_W-1:0]  ocol_s3, orow_s3;
	logic [SQ_W-1:0]   gx2_s3, gy2_s3;
	logic [MAG_W-1:0]  mag2;

	logic              out_v_q, out_last_q;
	logic [PIX_W-1:0]  out_pix_q;
	logic [POS_W-1:0]  out_col_q, out_row_q;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_THRESHOLD: threshold_q <= cfg.data;
				REG_WIDTH:     width_q     <= clamp_dim(cfg.data, WIDTH_MAX);
				REG_HEIGHT:    height_q    <= clamp_dim(cfg.data, HEIGHT_MAX);
				default: ;
			endcase
		end
	end

	assign lim      = {1'b0, threshold_q} + LIM_W'(1);
	assign lim_prod = lim * lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_sq_q <= LSQ_W'(10201);
		end else begin
			lim_sq_q <= lim_prod[LSQ_W-1:0];
		end
	end

	// Handshake and stage advance.
	assign adv_o   = !out_v_q || res.ready;
	assign adv_s3  = !v_s3 || adv_o;
	assign adv_s2  = !v_s2 || adv_s3;
	assign adv_s1  = !v_s1 || adv_s2;
	assign s1_exit = v_s1 && adv_s2;
	assign clr_done  = clr_q[ADDR_W];
	assign pix.ready = adv_s1 && clr_done;
	assign acc       = pix.valid && pix.ready;

	// Position of the incoming pixel and of the next one.
	always_comb begin
		c_a = pix.frame_start ? '0 : {1'b0, col_count_q};
		r_a = pix.frame_start ? '0 : {1'b0, row_count_q};
		if (c_a >= width_q) begin
			c_a = '0;
			r_a = r_a + CFG_W'(1);
		end
		if (r_a >= height_q) r_a = '0;
		c_cur = c_a[POS_W-1:0];
		r_cur = r_a[POS_W-1:0];
		c_n = c_a + CFG_W'(1);
		r_n = r_a;
		if (c_n >= width_q) begin
			c_n = '0;
			r_n = r_a + CFG_W'(1);
			if (r_n >= height_q) r_n = '0;
		end
		prod_cur = (c_a >= CFG_W'(2)) && (r_a >= CFG_W'(2));
		last_cur = (c_a == width_q - CFG_W'(1)) && (r_a == height_q - CFG_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (acc) begin
			col_count_q <= c_n[POS_W-1:0];
			row_count_q <= r_n[POS_W-1:0];
		end
	end

	// Line memory: older line in the upper byte, newer line in the lower byte.
	assign mem_we = !clr_done || s1_exit;
	assign mem_wa = clr_done ? addr_s1 : clr_q[ADDR_W-1:0];
	assign mem_wd = clr_done ? {mid_eff, bot_s1} : '0;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (acc) rd_s1 <= mem[c_cur[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_done) begin
			clr_q <= clr_q + (ADDR_W+1)'(1);
		end
	end

	// Stage 1: the pixel meets its column of the two lines above.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			prod_s1     <= prod_cur;
			last_s1     <= last_cur;
			addr_s1     <= c_cur[ADDR_W-1:0];
			ocol_s1     <= c_cur - POS_W'(1);
			orow_s1     <= r_cur - POS_W'(1);
			bot_s1      <= pix.pixel_in;
			fwd_s1      <= s1_exit && (addr_s1 == c_cur[ADDR_W-1:0]);
			fwd_word_s1 <= {mid_eff, bot_s1};
		end
	end

	// A write leaving stage 1 on the same edge as a read of that entry is forwarded.
	assign word_eff = fwd_s1 ? fwd_word_s1 : rd_s1;
	assign top_eff  = word_eff[2*PIX_W-1:PIX_W];
	assign mid_eff  = word_eff[PIX_W-1:0];

	assign left  = POS_W'(win_q[0]) + {1'b0, win_q[1], 1'b0} + POS_W'(win_q[2]);
	assign right = POS_W'(top_eff) + {1'b0, mid_eff, 1'b0} + POS_W'(bot_s1);
	assign upper = POS_W'(win_q[0]) + {1'b0, win_q[3], 1'b0} + POS_W'(top_eff);
	assign lower = POS_W'(win_q[2]) + {1'b0, win_q[5], 1'b0} + POS_W'(bot_s1);
	assign gx    = $signed({1'b0, right}) - $signed({1'b0, left});
	assign gy    = $signed({1'b0, lower}) - $signed({1'b0, upper});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (s1_exit) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_eff;
			win_q[4] <= mid_eff;
			win_q[5] <= bot_s1;
		end
	end

	// Stage 2: gradients.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1 && prod_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			gx_s2   <= gx;
			gy_s2   <= gy;
			ocol_s2 <= ocol_s1;
			orow_s2 <= orow_s1;
			last_s2 <= last_s1;
		end
	end

	assign gx_prod = gx_s2 * gx_s2;
	assign gy_prod = gy_s2 * gy_s2;

	// Stage 3: squared gradients.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			gx2_s3  <= gx_prod[SQ_W-1:0];
			gy2_s3  <= gy_prod[SQ_W-1:0];
			ocol_s3 <= ocol_s2;
			orow_s3 <= orow_s2;
			last_s3 <= last_s2;
		end
	end

	assign mag2 = MAG_W'(gx2_s3) + MAG_W'(gy2_s3);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_o) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o) begin
			out_pix_q  <= (LSQ_W'(mag2) >= lim_sq_q) ? EDGE_VAL : NO_EDGE_VAL;
			out_col_q  <= ocol_s3;
			out_row_q  <= orow_s3;
			out_last_q <= last_s3;
		end
	end

	assign res.valid      = out_v_q;
	assign res.edge_pixel = out_pix_q;
	assign res.out_col    = out_col_q;
	assign res.out_row    = out_row_q;
	assign res.frame_last = out_last_q;

`ifndef SYNTHESIS
	a_no_pixel_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> !pix.ready)
		else $error("pixel taken during line memory clearing");

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> ({1'b0, col_count_q} < $past(width_q)))
		else $error("column counter left the frame");

	a_result_interior: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.out_col != '0) && (res.out_row != '0))
		else $error("result for a border pixel");
`endif

endmodule

FILE: dv/edge_map_check.sv
`timescale 1ns / 100ps
// Edge map checker for the Sobel edge threshold block: follows the pixel, result and
// register channels, predicts each edge mark and compares it. Depends on sobel_pkg, sobel_if.
module edge_map_check (
	input  logic   clk,
	input  logic   arst_n,
	sobel_pix_if   pix,
	sobel_res_if   res,
	sobel_cfg_if   cfg,
	output int     mismatches,
	output int     pending,
	output int     results,
	output int     edges_seen,
	output int     frame_ends
);
	import sobel_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] mark;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             last;
	} edge_mark_t;

	edge_mark_t       marks_due[$];
	logic [PIX_W-1:0] older_line [MAX_WIDTH];
	logic [PIX_W-1:0] newer_line [MAX_WIDTH];
	logic [PIX_W-1:0] taps [6];
	logic [POS_W-1:0] col_at;
	logic [POS_W-1:0] row_at;
	logic [CFG_W-1:0] thr;
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;

	task automatic report_mismatch(input string note);
		begin
			$display("%0t: %s", $time, note);
			mismatches++;
		end
	endtask

	task automatic slide_window(input logic [PIX_W-1:0] bot, input logic fs);
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		logic [CFG_W-1:0] c;
		logic [CFG_W-1:0] r;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		int left, right, upper, lower, gx, gy, mag2, lim;
		edge_mark_t want;
		begin
			w = (width_reg < MIN_DIM) ? MIN_DIM : ((width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg);
			h = (height_reg < MIN_DIM) ? MIN_DIM :
				((height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg);
			c = {1'b0, col_at};
			r = {1'b0, row_at};
			if (fs) begin
				c = '0;
				r = '0;
			end
			if (c >= w) begin
				c = '0;
				r = r + 1'b1;
			end
			if (r >= h) r = '0;
			top = older_line[c[ADDR_W-1:0]];
			mid = newer_line[c[ADDR_W-1:0]];
			if (c >= 2 && r >= 2) begin
				left  = int'(taps[0]) + 2 * int'(taps[1]) + int'(taps[2]);
				right = int'(top) + 2 * int'(mid) + int'(bot);
				upper = int'(taps[0]) + 2 * int'(taps[3]) + int'(top);
				lower = int'(taps[2]) + 2 * int'(taps[5]) + int'(bot);
				gx = right - left;
				gy = lower - upper;
				mag2 = gx * gx + gy * gy;
				lim = int'(thr) + 1;
				want.mark = (mag2 >= lim * lim) ? EDGE_VAL : NO_EDGE_VAL;
				want.col  = POS_W'(c - 1'b1);
				want.row  = POS_W'(r - 1'b1);
				want.last = (c == w - 1'b1) && (r == h - 1'b1);
				marks_due.push_back(want);
			end
			taps[0] = taps[3];
			taps[1] = taps[4];
			taps[2] = taps[5];
			taps[3] = top;
			taps[4] = mid;
			taps[5] = bot;
			older_line[c[ADDR_W-1:0]] = mid;
			newer_line[c[ADDR_W-1:0]] = bot;
			c = c + 1'b1;
			if (c >= w) begin
				c = '0;
				r = r + 1'b1;
				if (r >= h) r = '0;
			end
			col_at = c[POS_W-1:0];
			row_at = r[POS_W-1:0];
		end
	endtask

	task automatic check_mark();
		edge_mark_t want;
		begin
			results++;
			if (res.edge_pixel == EDGE_VAL) edges_seen++;
			if (res.frame_last) frame_ends++;
			if (marks_due.size() == 0) begin
				report_mismatch($sformatf("result at row %0d col %0d with nothing expected",
					res.out_row, res.out_col));
			end else begin
				want = marks_due.pop_front();
				if (res.edge_pixel != want.mark)
					report_mismatch($sformatf("row %0d col %0d: edge_pixel %0d, expected %0d",
						want.row, want.col, res.edge_pixel, want.mark));
				if (res.out_col != want.col)
					report_mismatch($sformatf("row %0d col %0d: out_col %0d",
						want.row, want.col, res.out_col));
				if (res.out_row != want.row)
					report_mismatch($sformatf("row %0d col %0d: out_row %0d",
						want.row, want.col, res.out_row));
				if (res.frame_last != want.last)
					report_mismatch($sformatf("row %0d col %0d: frame_last %0d, expected %0d",
						want.row, want.col, res.frame_last, want.last));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				older_line[i] = '0;
				newer_line[i] = '0;
			end
			for (int i = 0; i < 6; i++) taps[i] = '0;
			col_at = '0;
			row_at = '0;
			thr = THRESHOLD_RST;
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			marks_due.delete();
			mismatches = 0;
			pending = 0;
			results = 0;
			edges_seen = 0;
			frame_ends = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_THRESHOLD: thr = cfg.data;
					REG_WIDTH:     width_reg = cfg.data;
					REG_HEIGHT:    height_reg = cfg.data;
					default:       ;
				endcase
			end
			if (pix.valid && pix.ready) slide_window(pix.pixel_in, pix.frame_start);
			if (res.valid && res.ready) check_mark();
			pending = marks_due.size();
		end
	end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the Sobel edge threshold testbench: clock, reset, pixel and register stimulus,
// result backpressure and verdict. Depends on sobel_pkg, sobel_if and edge_map_check.
module testbench;
	import sobel_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_PIXELS = 700;
	localparam int WIDE_PIXELS = 200;
	localparam int TALL_PIXELS = 300;

	logic clk;
	logic arst_n;
	bit   src_calm;
	bit   sink_calm;
	int   sent;
	int   phases;
	int   eff_w;
	int   eff_h;
	int   idle_cycles;
	int   mismatches, pending, results, edges_seen, frame_ends;

	sobel_pix_if pix_ch ();
	sobel_res_if res_ch ();
	sobel_cfg_if cfg_ch ();

	sobel_edge_threshold dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	edge_map_check map_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.results    (results),
		.edges_seen (edges_seen),
		.frame_ends (frame_ends)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : result_sink
		int hold;
		hold = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) hold = sink_calm ? 0 : $urandom_range(0, 7);
			@(negedge clk);
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				hold--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic [PIX_W-1:0] pick_level(input int mode, input int i);
		case (mode)
			0:       return PIX_W'($urandom_range(0, 255));
			1:       return $urandom_range(0, 1) ? NO_EDGE_VAL : EDGE_VAL;
			2:       return PIX_W'(100 + $urandom_range(0, 6));
			default: return PIX_W'(i * 17);
		endcase
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
		begin
			@(negedge clk);
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx;
			cfg_ch.data  <= value;
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
			@(negedge clk);
			cfg_ch.valid <= 1'b0;
			if (idx == REG_WIDTH)
				eff_w = (value < MIN_DIM) ? 3 : ((value > WIDTH_MAX) ? MAX_WIDTH : int'(value));
			if (idx == REG_HEIGHT)
				eff_h = (value < MIN_DIM) ? 3 : ((value > HEIGHT_MAX) ? MAX_HEIGHT : int'(value));
		end
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] value, input logic fs);
		int gap;
		begin
			gap = src_calm ? 0 : $urandom_range(0, 7);
			repeat (gap) begin
				@(negedge clk);
				pix_ch.valid <= 1'b0;
			end
			@(negedge clk);
			pix_ch.valid       <= 1'b1;
			pix_ch.pixel_in    <= value;
			pix_ch.frame_start <= fs;
			@(posedge clk);
			while (!pix_ch.ready) @(posedge clk);
			sent++;
		end
	endtask

	task automatic send_run(input int mode, input int count, input bit with_start);
		begin
			for (int i = 0; i < count; i++) send_pixel(pick_level(mode, i), with_start && i == 0);
		end
	endtask

	// The block is idle once every predicted result has left and the pipeline has drained.
	task automatic settle();
		begin
			@(negedge clk);
			pix_ch.valid <= 1'b0;
			while (pending != 0) @(negedge clk);
			repeat (8) @(negedge clk);
			phases++;
		end
	endtask

	initial begin
		int style;
		int mode;
		int goal;
		pix_ch.valid = 1'b0;
		pix_ch.pixel_in = '0;
		pix_ch.frame_start = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		sent = 0;
		phases = 0;
		eff_w = int'(WIDTH_RST);
		eff_h = int'(HEIGHT_RST);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Clamped geometry and an ignored register, threshold left at its reset value.
		write_reg(REG_WIDTH, CFG_W'(1));
		write_reg(REG_HEIGHT, CFG_W'(0));
		write_reg(REG_SPARE, 11'h7ff);
		for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? NO_EDGE_VAL : EDGE_VAL, i == 0);
		// The next frame follows without a frame start.
		for (int i = 0; i < 9; i++) send_pixel(NO_EDGE_VAL, 1'b0);
		settle();
		write_reg(REG_THRESHOLD, 11'h7ff);
		for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? NO_EDGE_VAL : EDGE_VAL, i == 0);

		goal = sent + RANDOM_PIXELS;
		while (sent < goal) begin
			settle();
			case ($urandom_range(0, 5))
				0:       write_reg(REG_THRESHOLD, CFG_W'(0));
				1:       write_reg(REG_THRESHOLD, 11'h7ff);
				2:       write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 60)));
				3:       write_reg(REG_THRESHOLD, CFG_W'($urandom_range(60, 400)));
				4:       write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 2047)));
				default: ;
			endcase
			if ($urandom_range(0, 9) != 0)
				write_reg(REG_WIDTH, ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2)) :
					CFG_W'($urandom_range(3, 12)));
			if ($urandom_range(0, 9) != 0)
				write_reg(REG_HEIGHT, ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2)) :
					CFG_W'($urandom_range(3, 8)));
			if ($urandom_range(0, 15) == 0) write_reg(REG_SPARE, CFG_W'($urandom_range(0, 2047)));
			src_calm = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			style = $urandom_range(0, 9);
			mode = $urandom_range(0, 3);
			if (style <= 6) begin
				repeat ($urandom_range(1, 2)) send_run(mode, eff_w * eff_h, 1'b1);
			end else if (style == 7) begin
				send_run(mode, $urandom_range(1, eff_w * eff_h - 1), 1'b1);
			end else if (style == 8) begin
				send_run(mode, $urandom_range(1, 40), 1'b0);
			end else begin
				repeat ($urandom_range(1, 40))
					send_pixel(PIX_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end
		end

		// The start of the widest and of the tallest frame.
		settle();
		src_calm = 1'b0;
		sink_calm = 1'b0;
		write_reg(REG_THRESHOLD, CFG_W'($urandom_range(100, 300)));
		write_reg(REG_WIDTH, 11'h7ff);
		write_reg(REG_HEIGHT, CFG_W'(3));
		send_run(0, WIDE_PIXELS, 1'b1);
		settle();
		write_reg(REG_WIDTH, CFG_W'(3));
		write_reg(REG_HEIGHT, CFG_W'(MAX_HEIGHT));
		send_run(1, TALL_PIXELS, 1'b1);

		settle();
		repeat (16) @(negedge clk);
		$display("Sent %0d pixels over %0d register settings and checked %0d results.",
			sent, phases, results);
		$display("The results held %0d edge pixels and %0d frame ends.", edges_seen, frame_ends);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
